// File: rtl/core/ycc565_pkg.sv
package ycc565_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned TERM_W   = 16;
  localparam int unsigned SUM_W    = TERM_W + 1;
  localparam int unsigned CLIP_W   = 14;

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic [PIXEL_W-1:0]       pixel_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CLIP_W-1:0]        clip_t;

  localparam logic signed [7:0] COEF_Y  = 8'sd74;
  localparam logic signed [7:0] COEF_RV = 8'sd101;
  localparam logic signed [7:0] COEF_GU = -8'sd24;
  localparam logic signed [7:0] COEF_GV = -8'sd51;

  localparam logic signed [9:0] LUMA_OFS = 10'sd16;
  localparam logic signed [9:0] CHR_OFS  = 10'sd128;

  localparam sum_t  SUM_MAX  = sum_t'(64 * 256 - 1);
  localparam clip_t CLIP_MAX = clip_t'(64 * 256 - 1);

  // shared chroma products, one set per pixel pair
  typedef struct packed {
    term_t rv;
    term_t guv;
    term_t bu;
  } chroma_terms_t;

endpackage

// File: rtl/core/ycc565_ifs.sv
interface ycc565_in_if;
  logic                  valid;
  logic                  ready;
  ycc565_pkg::sample_t   luma_first;
  ycc565_pkg::sample_t   luma_second;
  ycc565_pkg::sample_t   chroma_blue;
  ycc565_pkg::sample_t   chroma_red;

  modport source (output valid, luma_first, luma_second, chroma_blue, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, luma_second, chroma_blue, chroma_red,
                  output ready);
endinterface

interface ycc565_out_if;
  logic               valid;
  logic               ready;
  ycc565_pkg::pixel_t pixel_first;
  ycc565_pkg::pixel_t pixel_second;

  modport source (output valid, pixel_first, pixel_second, input ready);
  modport sink   (input valid, pixel_first, pixel_second, output ready);
endinterface

// File: rtl/core/ycbcr_to_rgb565_pair_core.sv
// YCbCr 4:2:0 pixel pair to RGB565 converter (BT.601 fixed point).
//
// Input channel in_pair carries two adjacent luma samples and the Cb/Cr
// pair they share; output channel out_pair carries both RGB565 pixels of
// that pair in one transaction. Both channels use valid/ready; a
// transaction completes on a clock edge with valid and ready high.
//
// Throughput: one pair per clock while out_pair.ready is high. The first
// stage registers the chroma products and the two per-lane luma products;
// the second stage adds, clips and packs in each lane and the output
// register merges both lanes.
//
// Each stage advances when it is empty or its successor advances, so
// bubbles close up and in_pair.ready stays high while one result waits.
// With out_pair.ready held low the pipe fills (two pairs) and then
// in_pair.ready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipe; no other state.
module ycbcr_to_rgb565_pair_core (
  input  logic          clk,
  input  logic          rst_n,
  ycc565_in_if.sink     in_pair,
  ycc565_out_if.source  out_pair
);
  import ycc565_pkg::*;

  chroma_terms_t terms;
  pixel_t        lane_first;
  pixel_t        lane_second;

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  pixel_t pixel_first_r;
  pixel_t pixel_second_r;
  logic   en_s1;
  logic   en_out;

  always_comb begin
    en_out        = !out_valid_r || out_pair.ready;
    en_s1         = !s1_valid_r || en_out;
    s1_valid_nxt  = en_s1 ? in_pair.valid : s1_valid_r;
    out_valid_nxt = en_out ? s1_valid_r : out_valid_r;
  end

  ycc565_chroma u_chroma (
    .clk         (clk),
    .en          (en_s1),
    .chroma_blue (in_pair.chroma_blue),
    .chroma_red  (in_pair.chroma_red),
    .terms       (terms)
  );

  ycc565_lane u_lane_first (
    .clk   (clk),
    .en    (en_s1),
    .luma  (in_pair.luma_first),
    .terms (terms),
    .pixel (lane_first)
  );

  ycc565_lane u_lane_second (
    .clk   (clk),
    .en    (en_s1),
    .luma  (in_pair.luma_second),
    .terms (terms),
    .pixel (lane_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      pixel_first_r  <= lane_first;
      pixel_second_r <= lane_second;
    end
  end

  assign in_pair.ready         = en_s1;
  assign out_pair.valid        = out_valid_r;
  assign out_pair.pixel_first  = pixel_first_r;
  assign out_pair.pixel_second = pixel_second_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipe not empty after reset");

  a_accept_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_pair.valid && in_pair.ready |=> s1_valid_r)
    else $error("accepted transaction lost at first stage");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && en_out |=> out_valid_r)
    else $error("first stage result not moved to output");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pair.ready && s1_valid_r |-> !in_pair.ready)
    else $error("input taken while pipe full and stalled");

endmodule

// File: rtl/core/ycc565_chroma.sv
module ycc565_chroma (
  input  logic                      clk,
  input  logic                      en,
  input  ycc565_pkg::sample_t       chroma_blue,
  input  ycc565_pkg::sample_t       chroma_red,
  output ycc565_pkg::chroma_terms_t terms
);
  import ycc565_pkg::*;

  logic signed [9:0] cb_ofs;
  logic signed [9:0] cr_ofs;
  chroma_terms_t     terms_r;
  chroma_terms_t     terms_nxt;

  always_comb begin
    cb_ofs        = $signed({2'b00, chroma_blue}) - CHR_OFS;
    cr_ofs        = $signed({2'b00, chroma_red}) - CHR_OFS;
    terms_nxt.rv  = term_t'(cr_ofs) * term_t'(COEF_RV);
    terms_nxt.guv = term_t'(cb_ofs) * term_t'(COEF_GU) + term_t'(cr_ofs) * term_t'(COEF_GV);
    terms_nxt.bu  = term_t'({cb_ofs, 7'b0000000});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// File: rtl/core/ycc565_lane.sv
module ycc565_lane (
  input  logic                      clk,
  input  logic                      en,
  input  ycc565_pkg::sample_t       luma,
  input  ycc565_pkg::chroma_terms_t terms,
  output ycc565_pkg::pixel_t        pixel
);
  import ycc565_pkg::*;

  logic signed [9:0] luma_ofs;
  term_t             ly_r;
  term_t             ly_nxt;
  sum_t              sum_r_c;
  sum_t              sum_g_c;
  sum_t              sum_b_c;
  clip_t             clip_r_c;
  clip_t             clip_g_c;
  clip_t             clip_b_c;

  function automatic clip_t clip_sum(input sum_t s);
    clip_t res;
    if (s < 0) begin
      res = '0;
    end else if (s > SUM_MAX) begin
      res = CLIP_MAX;
    end else begin
      res = s[CLIP_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    luma_ofs = $signed({2'b00, luma}) - LUMA_OFS;
    ly_nxt   = term_t'(luma_ofs) * term_t'(COEF_Y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ly_r <= ly_nxt;
    end
  end

  always_comb begin
    sum_r_c  = sum_t'(ly_r) + sum_t'(terms.rv);
    sum_g_c  = sum_t'(ly_r) + sum_t'(terms.guv);
    sum_b_c  = sum_t'(ly_r) + sum_t'(terms.bu);
    clip_r_c = clip_sum(sum_r_c);
    clip_g_c = clip_sum(sum_g_c);
    clip_b_c = clip_sum(sum_b_c);
    pixel    = {clip_r_c[13:9], clip_g_c[13:8], clip_b_c[13:9]};
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ycc565_pkg::*;

  localparam int Y_GAIN    = 74;
  localparam int RV_GAIN   = 101;
  localparam int GU_GAIN   = -24;
  localparam int GV_GAIN   = -51;
  localparam int BU_GAIN   = 128;
  localparam int Y_OFFSET  = 16;
  localparam int C_OFFSET  = 128;
  localparam int SUM_LIMIT = 64 * 256 - 1;
  localparam int RAND_PER_PHASE = 262;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct packed {
    sample_t y0;
    sample_t y1;
    sample_t cb;
    sample_t cr;
  } pair_t;

  typedef struct packed {
    pixel_t first;
    pixel_t second;
  } rgb_pair_t;

  logic clk;
  logic rst_n;

  ycc565_in_if  in_ch ();
  ycc565_out_if out_ch ();

  ycbcr_to_rgb565_pair_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pair (in_ch),
    .out_pair(out_ch)
  );

  pair_t     pending_pairs[$];
  rgb_pair_t expected_pixels[$];
  int        mismatch_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      in_taken;

  function automatic int clamp_sum(int v);
    if (v < 0) return 0;
    if (v > SUM_LIMIT) return SUM_LIMIT;
    return v;
  endfunction

  function automatic pixel_t rgb565_of(sample_t y, int rv, int guv, int bu);
    int ly;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    ly = Y_GAIN * (int'(y) - Y_OFFSET);
    r  = 5'(clamp_sum(ly + rv) >> 9);
    g  = 6'(clamp_sum(ly + guv) >> 8);
    b  = 5'(clamp_sum(ly + bu) >> 9);
    return {r, g, b};
  endfunction

  function automatic rgb_pair_t convert_pair(pair_t p);
    int cb, cr, rv, guv, bu;
    rgb_pair_t res;
    cb  = int'(p.cb) - C_OFFSET;
    cr  = int'(p.cr) - C_OFFSET;
    rv  = RV_GAIN * cr;
    guv = GU_GAIN * cb + GV_GAIN * cr;
    bu  = BU_GAIN * cb;
    res.first  = rgb565_of(p.y0, rv, guv, bu);
    res.second = rgb565_of(p.y1, rv, guv, bu);
    return res;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    if ($urandom_range(3) == 0) begin
      // typical studio-range video
      p.y0 = sample_t'($urandom_range(235, 16));
      p.y1 = sample_t'($urandom_range(235, 16));
      p.cb = sample_t'($urandom_range(168, 88));
      p.cr = sample_t'($urandom_range(168, 88));
    end else begin
      p = pair_t'($urandom);
    end
    return p;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // driver
  always @(negedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_pairs.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          p = pair_t'($urandom);
          in_ch.valid <= 1'b0;
        end
        in_ch.luma_first  <= p.y0;
        in_ch.luma_second <= p.y1;
        in_ch.chroma_blue <= p.cb;
        in_ch.chroma_red  <= p.cr;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    rgb_pair_t want;
    pair_t     p;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        $display("%0t: unexpected transaction, pixels %h %h", $time,
                 out_ch.pixel_first, out_ch.pixel_second);
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.pixel_first !== want.first) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: pixel_first expected %h actual %h", $time,
                   want.first, out_ch.pixel_first);
        end
        if (out_ch.pixel_second !== want.second) begin
          mismatch_count = mismatch_count + 1;
          $display("%0t: pixel_second expected %h actual %h", $time,
                   want.second, out_ch.pixel_second);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.y0 = in_ch.luma_first;
      p.y1 = in_ch.luma_second;
      p.cb = in_ch.chroma_blue;
      p.cr = in_ch.chroma_red;
      expected_pixels.push_back(convert_pair(p));
    end
  end

  task automatic drain();
    while (pending_pairs.size() != 0 || in_ch.valid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < RAND_PER_PHASE; i++) pending_pairs.push_back(random_pair());
    drain();
  endtask

  initial begin
    sample_t chroma_pts[3];
    pair_t   p;
    chroma_pts = '{8'd0, 8'd128, 8'd255};
    mismatch_count    = 0;
    cycle_count       = 0;
    in_taken          = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.luma_first  = '0;
    in_ch.luma_second = '0;
    in_ch.chroma_blue = '0;
    in_ch.chroma_red  = '0;
    out_ch.ready      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // chroma corners against luma extremes: both clamps on every component
    foreach (chroma_pts[i]) begin
      foreach (chroma_pts[j]) begin
        pending_pairs.push_back(pair_t'{8'd0, 8'd255, chroma_pts[i], chroma_pts[j]});
        pending_pairs.push_back(pair_t'{8'd255, 8'd16, chroma_pts[i], chroma_pts[j]});
      end
    end
    pending_pairs.push_back(pair_t'{8'd16, 8'd16, 8'd128, 8'd128});
    pending_pairs.push_back(pair_t'{8'd235, 8'd235, 8'd128, 8'd128});
    p = pair_t'{8'd128, 8'd127, 8'd64, 8'd192};
    pending_pairs.push_back(p);

    run_phase(0, 0);
    run_phase(66, 0);
    run_phase(0, 66);
    run_phase(28, 28);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
